@@ rtl/core/positional_ordered_list_assert.svh @@
// Assertion macros for the positional ordered list RTL.
// Expects clk and rst in the scope of the module that uses them.
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is high.
`define POL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define POL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define POL_ASSERT(lbl, prop, msg)
`define POL_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ rtl/core/pol_pkg.sv @@
// Shared types, codes and sizes for the positional ordered list.
// No dependencies; used by pol_cell and positional_ordered_list.
package pol_pkg;

  localparam int CAPACITY = 16;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef logic [CW-1:0] count_t;
  typedef logic [IW-1:0] idx_t;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_INSERT_AT  = 3'd2;
  localparam logic [2:0] MODE_DELETE_AT  = 3'd3;
  localparam logic [2:0] MODE_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_BAD_POS = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [7:0]         place;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [6:0]         length;
    logic signed [31:0] dump_value;
    logic               last;
  } rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e           op;
    idx_t               pos;
    count_t             cnt;
    logic signed [31:0] word;
  } cell_cmd_t;

endpackage

@@ rtl/core/pol_cell.sv @@
// One storage cell of the list row: holds one word, shifts with its neighbors.
// Depends on pol_pkg.
module pol_cell (
  input  logic                clk,
  input  pol_pkg::idx_t       index,
  input  pol_pkg::cell_cmd_t  cmd,
  input  logic signed [31:0]  left_word,
  input  logic signed [31:0]  right_word,
  output logic signed [31:0]  word
);

  pol_pkg::count_t idx_ext;
  pol_pkg::count_t idx_inc;

  assign idx_ext = pol_pkg::count_t'(index);
  assign idx_inc = idx_ext + pol_pkg::count_t'(1);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pol_pkg::CELL_INSERT: begin
        // open a slot at pos: cells above it take their left neighbor
        if (index == cmd.pos) begin
          word <= cmd.word;
        end else if (index > cmd.pos && idx_ext <= cmd.cnt) begin
          word <= left_word;
        end
      end
      pol_pkg::CELL_DELETE: begin
        if (index >= cmd.pos && idx_inc < cmd.cnt) begin
          word <= right_word;
        end
      end
      pol_pkg::CELL_ROTATE: begin
        // head word wraps to the tail
        if (idx_inc < cmd.cnt) begin
          word <= right_word;
        end else if (idx_inc == cmd.cnt) begin
          word <= cmd.word;
        end
      end
      default: begin
        word <= word;
      end
    endcase
  end

endmodule

@@ rtl/core/positional_ordered_list.sv @@
// Positional ordered list: a row of CAPACITY shifting cells plus a count.
// Insert, delete and unused modes: a request is taken in the idle state while the
// output register is free; the result is registered and shown the cycle after
// acceptance. Dump of n entries: one beat per entry, paced by rotating the cell row one place per beat.
// Reset (rst, synchronous) empties the list and drops any pending beat;
// cell words are not cleared and are only read once written.
`include "positional_ordered_list_assert.svh"

module positional_ordered_list (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  pol_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output pol_pkg::rsp_t   rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t             state, state_next;
  pol_pkg::count_t    count, count_next;
  pol_pkg::idx_t      dump_idx, dump_idx_next;
  pol_pkg::cell_cmd_t cmd;
  pol_pkg::rsp_t      result;
  logic               load;
  logic               out_free;
  logic               req_fire;
  logic               dump_last;
  logic               full;
  logic [7:0]         count_b;
  pol_pkg::idx_t      ins_pos;
  pol_pkg::idx_t      del_pos;
  logic signed [31:0] words [pol_pkg::CAPACITY];
  logic               over_cap;
  logic               ins_fire;
  pol_pkg::count_t    count_inc;
  logic               dump_end;
  logic               at_rest;

  // Row of cells; the ends see zero neighbors.
  for (genvar i = 0; i < pol_pkg::CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_w;
    logic signed [31:0] right_w;
    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_left
      assign left_w = words[i-1];
    end
    if (i == pol_pkg::CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_right
      assign right_w = words[i+1];
    end
    pol_cell u_cell (
      .clk        (clk),
      .index      (pol_pkg::idx_t'(i)),
      .cmd        (cmd),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i])
    );
  end

  // The output register frees up when empty or when its beat is taken.
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign req_fire  = req_valid && req_ready;
  assign full      = (count == pol_pkg::count_t'(pol_pkg::CAPACITY));
  assign count_b   = 8'(count);
  assign dump_last = ((pol_pkg::count_t'(dump_idx) + pol_pkg::count_t'(1)) == count);

  // Insert slot for the positioned insert: empty list or place one goes to
  // the front, a place past the length goes to the back.
  always_comb begin
    if (count == '0 || req.place == 8'd1) begin
      ins_pos = '0;
    end else if (req.place > count_b) begin
      ins_pos = pol_pkg::idx_t'(count);
    end else begin
      ins_pos = pol_pkg::idx_t'(req.place - 8'd1);
    end
  end

  // A one-entry list loses its entry whatever the place.
  assign del_pos = (count == pol_pkg::count_t'(1)) ? '0 : pol_pkg::idx_t'(req.place - 8'd1);

  always_comb begin
    cmd           = '{op: pol_pkg::CELL_HOLD, pos: '0, cnt: count, word: req.value};
    result        = '{status: pol_pkg::ST_OK, removed_value: '0, length: '0,
                      dump_value: '0, last: 1'b1};
    count_next    = count;
    state_next    = state;
    dump_idx_next = dump_idx;
    load          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          load = 1'b1;
          unique case (req.mode)
            pol_pkg::MODE_PUSH_FRONT, pol_pkg::MODE_PUSH_BACK: begin
              if (full) begin
                result.status = pol_pkg::ST_FULL;
              end else begin
                cmd.op     = pol_pkg::CELL_INSERT;
                cmd.pos    = (req.mode == pol_pkg::MODE_PUSH_FRONT) ? '0
                                                                   : pol_pkg::idx_t'(count);
                count_next = count + pol_pkg::count_t'(1);
              end
            end
            pol_pkg::MODE_INSERT_AT: begin
              if (full) begin
                result.status = pol_pkg::ST_FULL;
              end else if (req.place == 8'd0) begin
                result.status = pol_pkg::ST_BAD_POS;
              end else begin
                cmd.op     = pol_pkg::CELL_INSERT;
                cmd.pos    = ins_pos;
                count_next = count + pol_pkg::count_t'(1);
              end
            end
            pol_pkg::MODE_DELETE_AT: begin
              if (count == '0) begin
                result.status = pol_pkg::ST_EMPTY;
              end else if (count != pol_pkg::count_t'(1) &&
                           (req.place == 8'd0 || req.place > count_b)) begin
                result.status = pol_pkg::ST_BAD_POS;
              end else begin
                cmd.op               = pol_pkg::CELL_DELETE;
                cmd.pos              = del_pos;
                result.removed_value = words[del_pos];
                count_next           = count - pol_pkg::count_t'(1);
              end
            end
            pol_pkg::MODE_DUMP: begin
              if (count == '0) begin
                result.status = pol_pkg::ST_EMPTY;
              end else begin
                // no beat this cycle; the dump state streams the entries
                load          = 1'b0;
                state_next    = S_DUMP;
                dump_idx_next = '0;
              end
            end
            default: begin
              result.status = pol_pkg::ST_OK;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          // emit the head, rotate it to the tail
          load              = 1'b1;
          result.dump_value = words[0];
          result.last       = dump_last;
          cmd.op            = pol_pkg::CELL_ROTATE;
          cmd.word          = words[0];
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            dump_idx_next = dump_idx + pol_pkg::idx_t'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    result.length = 7'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dump_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload: hold until the next beat is loaded.
  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= result;
    end
  end

  // Terms for the checks below.
  assign over_cap  = (count > pol_pkg::count_t'(pol_pkg::CAPACITY));
  assign ins_fire  = req_fire && (cmd.op == pol_pkg::CELL_INSERT);
  assign count_inc = count + pol_pkg::count_t'(1);
  assign dump_end  = (state == S_DUMP) && load && dump_last;
  assign at_rest   = (count == '0) && !rsp_valid && (state == S_IDLE);

  `POL_ASSERT(a_count_bound, !over_cap, "count over capacity")
  `POL_ASSERT(a_dump_blocks, (state == S_DUMP) |-> !req_ready, "request taken during dump")
  `POL_ASSERT(a_insert_grows, ins_fire |=> (count == $past(count_inc)), "insert missed count")
  `POL_ASSERT(a_dump_ends, dump_end |=> (state == S_IDLE), "dump ran past its last beat")
  `POL_ASSERT_RST(a_reset_clears, rst |=> at_rest, "reset left state behind")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the positional ordered list: directed and random list traffic.
// Depends on pol_pkg (request and response types, mode and status codes) and the
// positional_ordered_list top module.
`timescale 1ns / 1ps

module testbench;

  // Run length guard: far above the slowest legal run, where every dump
  // beat waits out a full receiver stall.
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  pol_pkg::req_t  req       = '0;
  logic           rsp_ready = 1'b0;
  logic           req_ready;
  logic           rsp_valid;
  pol_pkg::rsp_t  rsp;

  // Shadow copy of the list contents, front of the list at index 0.
  logic signed [31:0] list_words[$];
  // Response beats still owed by the block, oldest first.
  pol_pkg::rsp_t      expected_rsp[$];

  // Sender pacing: a burst of back-to-back beats, then a gap with valid low.
  // gap_max of zero turns gaps off.
  int gap_max    = 0;
  int burst_max  = 1;
  int burst_left = 0;

  // Receiver pacing: ready follows a rotating 16-bit pattern, reloaded
  // each time pattern_age wraps; stall_free holds ready high.
  logic        stall_free    = 1'b1;
  logic        dense_stalls  = 1'b0;
  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_age   = 0;

  int cycle_count    = 0;
  int error_count    = 0;
  int beats_checked  = 0;
  int reqs_sent      = 0;
  int dump_beats     = 0;
  int full_rejects   = 0;
  int bad_positions  = 0;

  positional_ordered_list u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // Watchdog: end the run if the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_rsp.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Receiver: advance the stall pattern one place per cycle, reload it now
  // and then. Dense mode ANDs two random words, so stalls dominate;
  // otherwise OR them, so ready dominates.
  always @(posedge clk) begin
    if (stall_free) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= ready_pattern[0];
    end
    if (pattern_age >= 47) begin
      pattern_age   <= 0;
      ready_pattern <= dense_stalls ? 16'($urandom & $urandom) : 16'($urandom | $urandom);
    end else begin
      pattern_age   <= pattern_age + 1;
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // Checker: compare each accepted response beat with the oldest expectation.
  always @(posedge clk) begin
    pol_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      beats_checked++;
      if (expected_rsp.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected beat: status %0d removed %0d length %0d dump %0d last %0b",
                   rsp.status, rsp.removed_value, rsp.length, rsp.dump_value, rsp.last);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status || rsp.removed_value !== want.removed_value ||
            rsp.length !== want.length || rsp.dump_value !== want.dump_value ||
            rsp.last !== want.last) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  expected: status %0d removed %0d length %0d dump %0d last %0b",
                     want.status, want.removed_value, want.length, want.dump_value,
                     want.last);
            $display("  actual:   status %0d removed %0d length %0d dump %0d last %0b",
                     rsp.status, rsp.removed_value, rsp.length, rsp.dump_value, rsp.last);
          end
        end
      end
    end
  end

  // Apply one accepted request to the shadow list and queue the beats it owes.
  task automatic predict_list_op(input pol_pkg::req_t r);
    pol_pkg::rsp_t e;
    int            n;
    int            pl;
    n = list_words.size();
    pl = int'(r.place);
    e = '0;
    e.status = pol_pkg::ST_OK;
    e.last = 1'b1;
    case (r.mode)
      pol_pkg::MODE_PUSH_FRONT, pol_pkg::MODE_PUSH_BACK, pol_pkg::MODE_INSERT_AT: begin
        if (n >= pol_pkg::CAPACITY) begin
          e.status = pol_pkg::ST_FULL;
          full_rejects++;
        end else if (r.mode == pol_pkg::MODE_INSERT_AT && pl == 0) begin
          e.status = pol_pkg::ST_BAD_POS;
          bad_positions++;
        end else if (r.mode == pol_pkg::MODE_PUSH_FRONT ||
                     (r.mode == pol_pkg::MODE_INSERT_AT && (n == 0 || pl == 1))) begin
          list_words.push_front(r.value);
        end else if (r.mode == pol_pkg::MODE_PUSH_BACK || pl > n) begin
          list_words.push_back(r.value);
        end else begin
          list_words.insert(pl - 1, r.value);
        end
        e.length = 7'(list_words.size());
        expected_rsp.push_back(e);
      end
      pol_pkg::MODE_DELETE_AT: begin
        if (n == 0) begin
          e.status = pol_pkg::ST_EMPTY;
        end else if (n == 1) begin
          // A lone entry goes whatever the position.
          e.removed_value = list_words.pop_front();
        end else if (pl == 0 || pl > n) begin
          e.status = pol_pkg::ST_BAD_POS;
          bad_positions++;
        end else begin
          e.removed_value = list_words[pl - 1];
          list_words.delete(pl - 1);
        end
        e.length = 7'(list_words.size());
        expected_rsp.push_back(e);
      end
      pol_pkg::MODE_DUMP: begin
        if (n == 0) begin
          e.status = pol_pkg::ST_EMPTY;
          expected_rsp.push_back(e);
        end else begin
          for (int i = 0; i < n; i++) begin
            e.length = 7'(n);
            e.dump_value = list_words[i];
            e.last = (i == n - 1);
            expected_rsp.push_back(e);
            dump_beats++;
          end
        end
      end
      default: begin
        e.length = 7'(n);
        expected_rsp.push_back(e);
      end
    endcase
  endtask

  // Send one request beat. Called at a rising edge; returns at the edge that
  // accepted the beat, with valid still high so the next call can follow on.
  task automatic send_req(input pol_pkg::req_t r);
    int gap;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(burst_max, 1);
        gap = $urandom_range(gap_max, 1);
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    reqs_sent++;
    predict_list_op(r);
  endtask

  function automatic pol_pkg::req_t mk_req(input logic [2:0] mode,
                                           input logic signed [31:0] value,
                                           input logic [7:0] place);
    pol_pkg::req_t r;
    r.mode  = mode;
    r.value = value;
    r.place = place;
    return r;
  endfunction

  // Random request: grow_pct percent inserts, dump_pct percent dumps, the
  // rest deletes. Positions mostly land inside the list or just past it.
  function automatic pol_pkg::req_t make_random_req(input int grow_pct, input int dump_pct);
    pol_pkg::req_t r;
    int            roll;
    int            n;
    n = list_words.size();
    roll = $urandom_range(99, 0);
    if (roll < dump_pct)
      r.mode = pol_pkg::MODE_DUMP;
    else if (roll < dump_pct + grow_pct)
      case ($urandom_range(2, 0))
        0:       r.mode = pol_pkg::MODE_PUSH_FRONT;
        1:       r.mode = pol_pkg::MODE_PUSH_BACK;
        default: r.mode = pol_pkg::MODE_INSERT_AT;
      endcase
    else
      r.mode = pol_pkg::MODE_DELETE_AT;
    roll = $urandom_range(99, 0);
    if (roll < 55)      r.place = 8'($urandom_range(n + 1, 1));
    else if (roll < 70) r.place = 8'd255;
    else if (roll < 80) r.place = 8'd1;
    else                r.place = 8'($urandom_range(255, 1));
    roll = $urandom_range(99, 0);
    if (roll < 4)      r.value = 32'sh8000_0000;
    else if (roll < 8) r.value = 32'sh7FFF_FFFF;
    else if (roll < 11) r.value = '0;
    else if (roll < 14) r.value = -32'sd1;
    else               r.value = $urandom;
    return r;
  endfunction

  function automatic logic signed [31:0] any_word();
    return $urandom;
  endfunction

  // Empty list: dump and delete report empty; a positioned insert on an empty
  // list takes any place; a lone entry is deleted whatever the place.
  task automatic test_empty_list();
    send_req(mk_req(pol_pkg::MODE_DUMP, any_word(), 8'd1));
    send_req(mk_req(pol_pkg::MODE_DELETE_AT, any_word(), 8'd77));
    send_req(mk_req(pol_pkg::MODE_INSERT_AT, 32'sh1234_5678, 8'd200));
    send_req(mk_req(pol_pkg::MODE_DELETE_AT, any_word(), 8'd131));
    send_req(mk_req(pol_pkg::MODE_DUMP, any_word(), 8'd255));
  endtask

  // Front and back inserts with the extreme words.
  task automatic test_insert_ends();
    send_req(mk_req(pol_pkg::MODE_PUSH_FRONT, 32'sh8000_0000, 8'd1));
    send_req(mk_req(pol_pkg::MODE_PUSH_BACK, 32'sh7FFF_FFFF, 8'd255));
    send_req(mk_req(pol_pkg::MODE_PUSH_FRONT, '0, 8'd128));
    send_req(mk_req(pol_pkg::MODE_PUSH_BACK, -32'sd1, 8'd64));
    send_req(mk_req(pol_pkg::MODE_DUMP, any_word(), 8'd1));
  endtask

  // Positioned inserts: front, middle, and past the length.
  task automatic test_insert_positions();
    send_req(mk_req(pol_pkg::MODE_INSERT_AT, 32'sh0000_0011, 8'd1));
    send_req(mk_req(pol_pkg::MODE_INSERT_AT, 32'sh0000_0033, 8'd3));
    send_req(mk_req(pol_pkg::MODE_INSERT_AT, 32'shDEAD_BEEF, 8'd255));
    send_req(mk_req(pol_pkg::MODE_DUMP, any_word(), 8'd2));
  endtask

  // Deletes: past the length, front, middle, last entry.
  task automatic test_delete_positions();
    send_req(mk_req(pol_pkg::MODE_DELETE_AT, any_word(), 8'd255));
    send_req(mk_req(pol_pkg::MODE_DELETE_AT, any_word(), 8'd1));
    send_req(mk_req(pol_pkg::MODE_DELETE_AT, any_word(), 8'd3));
    send_req(mk_req(pol_pkg::MODE_DELETE_AT, any_word(), 8'(list_words.size())));
    send_req(mk_req(pol_pkg::MODE_DUMP, any_word(), 8'd170));
  endtask

  // Fill to capacity, hit the full status with every insert kind, dump the
  // whole row.
  task automatic test_full_list();
    while (list_words.size() < pol_pkg::CAPACITY)
      send_req(make_random_req(100, 0));
    send_req(mk_req(pol_pkg::MODE_PUSH_FRONT, any_word(), 8'd1));
    send_req(mk_req(pol_pkg::MODE_PUSH_BACK, any_word(), 8'd85));
    send_req(mk_req(pol_pkg::MODE_INSERT_AT, any_word(), 8'd8));
    send_req(mk_req(pol_pkg::MODE_DUMP, any_word(), 8'd1));
  endtask

  // Mixed random traffic with gaps and receiver stalls.
  task automatic test_random_mixed(input int count);
    gap_max = 4;
    burst_max = 12;
    stall_free = 1'b0;
    dense_stalls = 1'b0;
    repeat (count) send_req(make_random_req(50, 8));
  endtask

  // Swing between growing and shrinking so the list keeps crossing empty and
  // full, under heavy stalls.
  task automatic test_random_grow_shrink(input int count);
    gap_max = 6;
    burst_max = 5;
    stall_free = 1'b0;
    dense_stalls = 1'b1;
    for (int i = 0; i < count; i++)
      send_req(make_random_req(((i / 25) % 2 == 0) ? 80 : 20, 8));
  endtask

  // Back-to-back traffic: no gaps, receiver always ready.
  task automatic test_random_no_idle(input int count);
    gap_max = 0;
    stall_free = 1'b1;
    repeat (count) send_req(make_random_req(55, 10));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_insert_ends();
    test_insert_positions();
    test_delete_positions();
    test_full_list();
    test_random_mixed(140);
    test_random_grow_shrink(150);
    test_random_no_idle(100);

    // Drop valid, drain every owed beat, then let the pipeline settle.
    req_valid <= 1'b0;
    stall_free = 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    error_count += expected_rsp.size();

    $display("covered %0d requests and %0d response beats: %0d dump entries,",
             reqs_sent, beats_checked, dump_beats);
    $display("%0d full rejects, %0d bad positions, %0d errors",
             full_rejects, bad_positions, error_count);
    if (error_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
